>>> rtl/lsmt_pkg.sv
// shared types and constants of the learning switch mac table
package lsmt_pkg;

    localparam int MAC_W = 48;
    localparam int PORT_W = 5;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int PORT_COUNT_DEF = 16;

    typedef struct packed {
        logic [MAC_W-1:0]  source_mac;
        logic [MAC_W-1:0]  dest_mac;
        logic [PORT_W-1:0] ingress_port;
    } frame_t;

    typedef struct packed {
        logic [PORT_W-1:0] egress_port;
        logic              flood;
        logic              table_full;
    } result_t;

    typedef struct packed {
        logic load;
        logic read;
        logic write;
    } lsmt_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
    } lsmt_status_t;

endpackage

>>> rtl/learning_switch_mac_table_top.sv
// top level of the learning switch mac address table
//
// A frame transfer is taken when start is high and busy is low. The table holds
// its entries in fill order, so each frame scans only the filled entries through
// one memory read port, one entry per cycle; the scan and a drain state (both
// skipped on an empty table) lead to a write state, from which the result is
// registered, and the next frame can be taken on the cycle of the result.
// The result appears for exactly one cycle with done high; the receiver cannot
// stall it, so it must take every result as it comes. Entries are never aged out.
module learning_switch_mac_table_top #(
    parameter int TABLE_ENTRIES = lsmt_pkg::TABLE_ENTRIES_DEF,
    parameter int PORT_COUNT    = lsmt_pkg::PORT_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lsmt_pkg::frame_t  frame,
    output logic              done,
    output lsmt_pkg::result_t result
);
    import lsmt_pkg::*;

    lsmt_cmd_t    cmd;
    lsmt_status_t status;

    lsmt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    lsmt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PORT_COUNT    (PORT_COUNT)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame),
        .cmd    (cmd),
        .status (status),
        .done   (done),
        .result (result)
    );

endmodule

>>> rtl/lsmt_ctrl.sv
// controller state machine sequencing the table scan, learn write and result
module lsmt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output lsmt_pkg::lsmt_cmd_t   cmd,
    input  lsmt_pkg::lsmt_status_t status
);
    import lsmt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = status.empty ? S_WRITE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cmd.load  = (state_reg == S_IDLE) && start;
    assign cmd.read  = (state_reg == S_SCAN);
    assign cmd.write = (state_reg == S_WRITE);

endmodule

>>> rtl/lsmt_datapath.sv
// table memories, fill count, scan compare and result registers
module lsmt_datapath #(
    parameter int TABLE_ENTRIES = lsmt_pkg::TABLE_ENTRIES_DEF,
    parameter int PORT_COUNT    = lsmt_pkg::PORT_COUNT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lsmt_pkg::frame_t       frame,
    input  lsmt_pkg::lsmt_cmd_t    cmd,
    output lsmt_pkg::lsmt_status_t status,
    output logic                   done,
    output lsmt_pkg::result_t      result
);
    import lsmt_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int PCW = $clog2(PORT_COUNT + 1) > PORT_W ? $clog2(PORT_COUNT + 1) : PORT_W;

    logic [MAC_W-1:0]  mac_mem [TABLE_ENTRIES];
    logic [PORT_W-1:0] port_mem [TABLE_ENTRIES];

    frame_t            frame_reg;
    logic [CW-1:0]     cnt_reg;
    logic [AW-1:0]     addr_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic [MAC_W-1:0]  rd_mac_reg;
    logic [PORT_W-1:0] rd_port_reg;
    logic              src_hit_reg;
    logic [AW-1:0]     src_idx_reg;
    logic              dst_hit_reg;
    logic [PORT_W-1:0] dst_port_reg;
    result_t           result_reg;
    logic              done_reg;

    logic              learn;
    logic              full;
    logic              learned;
    logic              src_match;
    logic              dst_match;
    logic              port_we;
    logic              mac_we;
    logic [AW-1:0]     wr_addr;
    result_t           result_next;

    assign learn = (frame_reg.ingress_port != '0)
                && (PCW'(frame_reg.ingress_port) <= PCW'(PORT_COUNT));
    assign full    = (cnt_reg == CW'(TABLE_ENTRIES));
    assign learned = learn && (src_hit_reg || !full);

    assign src_match = rd_valid_reg && (rd_mac_reg == frame_reg.source_mac);
    assign dst_match = rd_valid_reg && (rd_mac_reg == frame_reg.dest_mac);

    assign status.empty = (cnt_reg == '0);
    assign status.last  = ((CW'(addr_reg) + CW'(1)) == cnt_reg);

    assign port_we = cmd.write && learned;
    assign mac_we  = cmd.write && learn && !src_hit_reg && !full;
    assign wr_addr = src_hit_reg ? src_idx_reg : cnt_reg[AW-1:0];

    always_comb
    begin
        result_next = '0;
        if (learned && (frame_reg.dest_mac == frame_reg.source_mac))
        begin
            result_next.egress_port = frame_reg.ingress_port;
        end
        else if (dst_hit_reg)
        begin
            result_next.egress_port = dst_port_reg;
        end
        else
        begin
            result_next.flood = 1'b1;
        end
        result_next.table_full = learn && !src_hit_reg && full;
    end

    // table storage
    always_ff @(posedge clk)
    begin
        if (mac_we)
        begin
            mac_mem[wr_addr] <= frame_reg.source_mac;
        end
        if (port_we)
        begin
            port_mem[wr_addr] <= frame_reg.ingress_port;
        end
        if (cmd.read)
        begin
            rd_mac_reg  <= mac_mem[addr_reg];
            rd_port_reg <= port_mem[addr_reg];
            rd_idx_reg  <= addr_reg;
        end
    end

    // payload captured per transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            frame_reg <= frame;
        end
        if (src_match && !src_hit_reg)
        begin
            src_idx_reg <= rd_idx_reg;
        end
        if (dst_match && !dst_hit_reg)
        begin
            dst_port_reg <= rd_port_reg;
        end
        if (cmd.write)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            src_hit_reg  <= 1'b0;
            dst_hit_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.read;
            done_reg     <= cmd.write;
            if (cmd.load)
            begin
                addr_reg    <= '0;
                src_hit_reg <= 1'b0;
                dst_hit_reg <= 1'b0;
            end
            else
            begin
                if (cmd.read)
                begin
                    addr_reg <= addr_reg + AW'(1);
                end
                if (src_match)
                begin
                    src_hit_reg <= 1'b1;
                end
                if (dst_match)
                begin
                    dst_hit_reg <= 1'b1;
                end
            end
            if (mac_we)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
